FILE: rtl/vfcao_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfcao_pkg
// Shared types, tables and helper functions of the voxel face culling and
// ambient occlusion core.
// ----------------------------------------------------------------------------
package vfcao_pkg;

	localparam int NUM_FACES  = 6;
	localparam int RING_SIZE  = 8;
	localparam int NUM_VERTS  = 4;
	localparam int HOOD_W     = 27;
	localparam int LIGHT_W    = 48;
	localparam int COORD_W    = 4;
	localparam int KIND_W     = 8;
	localparam int FACE_W     = 3;
	localparam int AO_W       = 8;
	localparam int LEVEL_W    = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [0:0] REG_AIR_CODE = 1'd0;

	localparam logic [FACE_W-1:0] LAST_FACE_CODE = 3'd5;

	// Neighborhood bit of each of the eight plane neighbors around a face.
	localparam logic [4:0] RING_BIT [NUM_FACES][RING_SIZE] = '{
		'{5'd0,  5'd1,  5'd2,  5'd3,  5'd5,  5'd6,  5'd7,  5'd8},
		'{5'd18, 5'd19, 5'd20, 5'd21, 5'd23, 5'd24, 5'd25, 5'd26},
		'{5'd0,  5'd9,  5'd18, 5'd1,  5'd19, 5'd2,  5'd11, 5'd20},
		'{5'd6,  5'd15, 5'd24, 5'd7,  5'd25, 5'd8,  5'd17, 5'd26},
		'{5'd0,  5'd9,  5'd18, 5'd3,  5'd21, 5'd6,  5'd15, 5'd24},
		'{5'd2,  5'd11, 5'd20, 5'd5,  5'd23, 5'd8,  5'd17, 5'd26}
	};

	// Ring positions of side one, side two and corner for each vertex.
	localparam logic [2:0] VERT_SEL [NUM_FACES][NUM_VERTS][3] = '{
		'{'{3'd1, 3'd3, 3'd0}, '{3'd1, 3'd4, 3'd2}, '{3'd6, 3'd4, 3'd7}, '{3'd6, 3'd3, 3'd5}},
		'{'{3'd1, 3'd4, 3'd2}, '{3'd1, 3'd3, 3'd0}, '{3'd6, 3'd3, 3'd5}, '{3'd6, 3'd4, 3'd7}},
		'{'{3'd1, 3'd4, 3'd2}, '{3'd1, 3'd3, 3'd0}, '{3'd6, 3'd3, 3'd5}, '{3'd6, 3'd4, 3'd7}},
		'{'{3'd4, 3'd1, 3'd2}, '{3'd3, 3'd1, 3'd0}, '{3'd3, 3'd6, 3'd5}, '{3'd4, 3'd6, 3'd7}},
		'{'{3'd1, 3'd4, 3'd2}, '{3'd1, 3'd3, 3'd0}, '{3'd6, 3'd3, 3'd5}, '{3'd6, 3'd4, 3'd7}},
		'{'{3'd1, 3'd3, 3'd0}, '{3'd1, 3'd4, 3'd2}, '{3'd6, 3'd4, 3'd7}, '{3'd6, 3'd3, 3'd5}}
	};

	// Neighborhood bit of the neighbor directly across each face.
	localparam logic [4:0] FACE_BIT [NUM_FACES] = '{5'd4, 5'd22, 5'd10, 5'd16, 5'd12, 5'd14};

	typedef struct packed {
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [COORD_W-1:0]   z;
		logic [KIND_W-1:0]    kind;
		logic [HOOD_W-1:0]    hood;
		logic [LIGHT_W-1:0]   light;
		logic [NUM_FACES-1:0] mask;
	} voxel_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [NUM_FACES-1:0] visible_mask(input logic [HOOD_W-1:0] hood);
		logic [NUM_FACES-1:0] m;
		for (int f = 0; f < NUM_FACES; f++) begin
			m[f] = ~hood[FACE_BIT[f]];
		end
		return m;
	endfunction

	function automatic logic [FACE_W-1:0] first_face(input logic [NUM_FACES-1:0] mask);
		logic [FACE_W-1:0] sel;
		sel = '0;
		for (int f = NUM_FACES - 1; f >= 0; f--) begin
			if (mask[f]) begin
				sel = FACE_W'(f);
			end
		end
		return sel;
	endfunction

	function automatic logic [AO_W-1:0] face_ao(input logic [HOOD_W-1:0] hood,
		input logic [FACE_W-1:0] f);
		logic [RING_SIZE-1:0] n;
		logic                 s1;
		logic                 s2;
		logic                 c;
		logic [1:0]           v;
		logic [AO_W-1:0]      packed_ao;
		packed_ao = '0;
		if (f <= LAST_FACE_CODE) begin
			for (int k = 0; k < RING_SIZE; k++) begin
				n[k] = hood[RING_BIT[f][k]];
			end
			for (int k = 0; k < NUM_VERTS; k++) begin
				s1 = n[VERT_SEL[f][k][0]];
				s2 = n[VERT_SEL[f][k][1]];
				c  = n[VERT_SEL[f][k][2]];
				if (s1 && s2) begin
					v = 2'd0;
				end else begin
					v = 2'd3 - ({1'b0, s1} + {1'b0, s2} + {1'b0, c});
				end
				packed_ao[2*k +: 2] = v;
			end
		end
		return packed_ao;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/vfcao_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfcao_front
// Accepts voxels, drops air and fully enclosed ones, and writes the rest with
// their visible face mask into the face queue.
// ----------------------------------------------------------------------------
module vfcao_front (
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [vfcao_pkg::COORD_W-1:0]  x_pos,
	input  wire logic [vfcao_pkg::COORD_W-1:0]  y_pos,
	input  wire logic [vfcao_pkg::COORD_W-1:0]  z_pos,
	input  wire logic [vfcao_pkg::KIND_W-1:0]   block_kind,
	input  wire logic [vfcao_pkg::HOOD_W-1:0]   neighborhood_solid,
	input  wire logic [vfcao_pkg::LIGHT_W-1:0]  face_light,
	input  wire logic [vfcao_pkg::KIND_W-1:0]   air_code,
	input  wire vfcao_pkg::queue_status_t       q_status,
	output logic                                q_wr,
	output vfcao_pkg::voxel_t                   q_wr_data
);

	logic [vfcao_pkg::NUM_FACES-1:0] mask;

	assign mask = vfcao_pkg::visible_mask(neighborhood_solid);
	assign full = q_status.full;

	always_comb begin
		q_wr_data.x     = x_pos;
		q_wr_data.y     = y_pos;
		q_wr_data.z     = z_pos;
		q_wr_data.kind  = block_kind;
		q_wr_data.hood  = neighborhood_solid;
		q_wr_data.light = face_light;
		q_wr_data.mask  = mask;
	end

	assign q_wr = push && !q_status.full && (block_kind != air_code) && (mask != '0);

endmodule
`default_nettype wire

FILE: rtl/vfcao_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfcao_queue
// Short queue of visible voxels between the classifier and the face emitter.
// ----------------------------------------------------------------------------
module vfcao_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr,
	input  wire vfcao_pkg::voxel_t        wr_data,
	input  wire logic                     rd,
	output vfcao_pkg::voxel_t             rd_data,
	output vfcao_pkg::queue_status_t      status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	vfcao_pkg::voxel_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr        = wr && !status.full;
	assign do_rd        = rd && !status.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/vfcao_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfcao_back
// Face emitter: walks the visible faces of the current voxel one a cycle while
// the output register is free or popped, computes each face's ambient occlusion
// and holds the result in that output register until it is taken.
// ----------------------------------------------------------------------------
module vfcao_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire vfcao_pkg::queue_status_t        q_status,
	input  wire vfcao_pkg::voxel_t               q_rd_data,
	output logic                                 q_rd,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [vfcao_pkg::COORD_W-1:0]        out_x,
	output logic [vfcao_pkg::COORD_W-1:0]        out_y,
	output logic [vfcao_pkg::COORD_W-1:0]        out_z,
	output logic [vfcao_pkg::FACE_W-1:0]         face,
	output logic [vfcao_pkg::AO_W-1:0]           ao_packed,
	output logic [vfcao_pkg::KIND_W-1:0]         out_block_kind,
	output logic [vfcao_pkg::LEVEL_W-1:0]        face_light_level,
	output logic                                 last_face
);

	vfcao_pkg::voxel_t               cur_q;
	logic                            cur_v_q;
	logic [vfcao_pkg::NUM_FACES-1:0] rem_q;
	logic                            out_v_q;
	logic [vfcao_pkg::FACE_W-1:0]    sel_face;
	logic [vfcao_pkg::NUM_FACES-1:0] sel_bit;
	logic [vfcao_pkg::NUM_FACES-1:0] rem_next;
	logic                            out_free;
	logic                            emit;
	logic                            last;
	logic                            load;

	assign sel_face = vfcao_pkg::first_face(rem_q);
	assign sel_bit  = rem_q & (~rem_q + 1'b1);
	assign rem_next = rem_q & ~sel_bit;
	assign out_free = !out_v_q || pop;
	assign emit     = cur_v_q && out_free;
	assign last     = emit && (rem_next == '0);
	assign load     = !q_status.empty && (!cur_v_q || last);
	assign q_rd     = load;
	assign empty    = !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				cur_v_q <= 1'b1;
			end else if (last) begin
				cur_v_q <= 1'b0;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_rd_data;
			rem_q <= q_rd_data.mask;
		end else if (emit) begin
			rem_q <= rem_next;
		end
		if (emit) begin
			out_x            <= cur_q.x;
			out_y            <= cur_q.y;
			out_z            <= cur_q.z;
			face             <= sel_face;
			ao_packed        <= vfcao_pkg::face_ao(cur_q.hood, sel_face);
			out_block_kind   <= cur_q.kind;
			face_light_level <= cur_q.light[{sel_face, 3'b000} +: vfcao_pkg::LEVEL_W];
			last_face        <= (rem_next == '0);
		end
	end

	a_cur_has_faces: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> (rem_q != '0))
		else $error("Current voxel is held with no faces left.");

	a_face_retired: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !last) |=> (cur_v_q && ($countones(rem_q) == $countones($past(rem_q)) - 1)))
		else $error("Emitting a face did not retire exactly one face.");

	a_more_faces_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !last_face) |-> cur_v_q)
		else $error("A face not marked last has no voxel behind it.");

	a_face_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (face <= vfcao_pkg::LAST_FACE_CODE))
		else $error("Result carries a face code beyond the six faces.");

endmodule
`default_nettype wire

FILE: rtl/voxel_face_cull_ambient_occlusion_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_face_cull_ambient_occlusion_core
// Voxel face culling with per-vertex ambient occlusion.
// ----------------------------------------------------------------------------
// A voxel is accepted every cycle while the face queue has room. Air voxels
// and voxels with no air face neighbour are taken and give no result. Every
// other voxel goes into a queue of QUEUE_DEPTH entries, and the face emitter
// gives one result per cycle while its single result register is free or
// popped, so a voxel with k visible faces holds the emitter until its last
// face is out. A voxel passes from the queue to the emitter's current voxel
// register, and each face result is registered in the result register.
// The air code register sits at byte address 0 of the configuration port.
// ----------------------------------------------------------------------------
module voxel_face_cull_ambient_occlusion_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [vfcao_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [vfcao_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [vfcao_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                   pready,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [vfcao_pkg::COORD_W-1:0]     x_pos,
	input  wire logic [vfcao_pkg::COORD_W-1:0]     y_pos,
	input  wire logic [vfcao_pkg::COORD_W-1:0]     z_pos,
	input  wire logic [vfcao_pkg::KIND_W-1:0]      block_kind,
	input  wire logic [vfcao_pkg::HOOD_W-1:0]      neighborhood_solid,
	input  wire logic [vfcao_pkg::LIGHT_W-1:0]     face_light,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [vfcao_pkg::COORD_W-1:0]          out_x,
	output logic [vfcao_pkg::COORD_W-1:0]          out_y,
	output logic [vfcao_pkg::COORD_W-1:0]          out_z,
	output logic [vfcao_pkg::FACE_W-1:0]           face,
	output logic [vfcao_pkg::AO_W-1:0]             ao_packed,
	output logic [vfcao_pkg::KIND_W-1:0]           out_block_kind,
	output logic [vfcao_pkg::LEVEL_W-1:0]          face_light_level,
	output logic                                   last_face
);

	logic [vfcao_pkg::KIND_W-1:0] air_code_q;
	logic                         reg_sel;
	vfcao_pkg::queue_status_t     q_status;
	vfcao_pkg::voxel_t            q_wr_data;
	vfcao_pkg::voxel_t            q_rd_data;
	logic                         q_wr;
	logic                         q_rd;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == vfcao_pkg::REG_AIR_CODE);
	assign prdata  = reg_sel ? {{(vfcao_pkg::APB_DATA_W - vfcao_pkg::KIND_W){1'b0}}, air_code_q}
	                         : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_code_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			air_code_q <= pwdata[vfcao_pkg::KIND_W-1:0];
		end
	end

	vfcao_front u_front (
		.push               (push),
		.full               (full),
		.x_pos              (x_pos),
		.y_pos              (y_pos),
		.z_pos              (z_pos),
		.block_kind         (block_kind),
		.neighborhood_solid (neighborhood_solid),
		.face_light         (face_light),
		.air_code           (air_code_q),
		.q_status           (q_status),
		.q_wr               (q_wr),
		.q_wr_data          (q_wr_data)
	);

	vfcao_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.status  (q_status)
	);

	vfcao_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_status         (q_status),
		.q_rd_data        (q_rd_data),
		.q_rd             (q_rd),
		.empty            (empty),
		.pop              (pop),
		.out_x            (out_x),
		.out_y            (out_y),
		.out_z            (out_z),
		.face             (face),
		.ao_packed        (ao_packed),
		.out_block_kind   (out_block_kind),
		.face_light_level (face_light_level),
		.last_face        (last_face)
	);

endmodule
`default_nettype wire

FILE: sim/tb_voxel_face_cull_ambient_occlusion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_face_cull_ambient_occlusion_core
// Streams voxels into the face culling and ambient occlusion core and checks
// every emitted face against an in-bench prediction of visibility, vertex
// occlusion, light and last-face marking. A short directed set covers air,
// enclosed and fully exposed voxels and field extremes. Random phases then
// follow, each under its own air code and its own mix of sender and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_voxel_face_cull_ambient_occlusion_core;

	localparam int         NUM_FACES    = vfcao_pkg::NUM_FACES;
	localparam int         HOOD_W       = vfcao_pkg::HOOD_W;
	localparam int         LIGHT_W      = vfcao_pkg::LIGHT_W;
	localparam int         COORD_W      = vfcao_pkg::COORD_W;
	localparam int         KIND_W       = vfcao_pkg::KIND_W;
	localparam int         FACE_W       = vfcao_pkg::FACE_W;
	localparam int         AO_W         = vfcao_pkg::AO_W;
	localparam int         LEVEL_W      = vfcao_pkg::LEVEL_W;
	localparam int         APB_ADDR_W   = vfcao_pkg::APB_ADDR_W;
	localparam int         APB_DATA_W   = vfcao_pkg::APB_DATA_W;
	localparam logic [0:0] REG_AIR_CODE = vfcao_pkg::REG_AIR_CODE;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_WAIT       = 11;
	localparam int PHASE_ITEMS    = 88;
	localparam int ACROSS_FACE    = 4;
	localparam logic [APB_ADDR_W-1:0] AIR_CODE_ADDR = APB_ADDR_W'(4 * REG_AIR_CODE);
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR    = APB_ADDR_W'(4 * (REG_AIR_CODE + 1));
	localparam logic [LEVEL_W-1:0]    MISSING_LIGHT = 8'd240;

	// Rim positions of side one, side two and corner for the four vertices of each face.
	localparam logic [0:5][0:11][2:0] VERTEX_REFS = {
		{3'd1, 3'd3, 3'd0, 3'd1, 3'd4, 3'd2, 3'd6, 3'd4, 3'd7, 3'd6, 3'd3, 3'd5},
		{3'd1, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0, 3'd6, 3'd3, 3'd5, 3'd6, 3'd4, 3'd7},
		{3'd1, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0, 3'd6, 3'd3, 3'd5, 3'd6, 3'd4, 3'd7},
		{3'd4, 3'd1, 3'd2, 3'd3, 3'd1, 3'd0, 3'd3, 3'd6, 3'd5, 3'd4, 3'd6, 3'd7},
		{3'd1, 3'd4, 3'd2, 3'd1, 3'd3, 3'd0, 3'd6, 3'd3, 3'd5, 3'd6, 3'd4, 3'd7},
		{3'd1, 3'd3, 3'd0, 3'd1, 3'd4, 3'd2, 3'd6, 3'd4, 3'd7, 3'd6, 3'd3, 3'd5}
	};

	typedef enum logic [FACE_W-1:0] {
		FACE_NEG_X,
		FACE_POS_X,
		FACE_NEG_Y,
		FACE_POS_Y,
		FACE_NEG_Z,
		FACE_POS_Z
	} face_dir_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [KIND_W-1:0]  kind;
		logic [HOOD_W-1:0]  hood;
		logic [LIGHT_W-1:0] light;
	} voxel_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		face_dir_t          dir;
		logic [AO_W-1:0]    ao;
		logic [KIND_W-1:0]  kind;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} face_result_t;

	logic                    clk;
	logic                    arst_n  = 1'b0;
	logic                    psel    = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0]   paddr   = '0;
	logic [APB_DATA_W-1:0]   pwdata  = '0;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;
	logic                    push    = 1'b0;
	logic                    full;
	logic [COORD_W-1:0]      x_pos   = '0;
	logic [COORD_W-1:0]      y_pos   = '0;
	logic [COORD_W-1:0]      z_pos   = '0;
	logic [KIND_W-1:0]       block_kind = '0;
	logic [HOOD_W-1:0]       neighborhood_solid = '0;
	logic [LIGHT_W-1:0]      face_light = '0;
	logic                    empty;
	logic                    pop     = 1'b0;
	logic [COORD_W-1:0]      out_x;
	logic [COORD_W-1:0]      out_y;
	logic [COORD_W-1:0]      out_z;
	logic [FACE_W-1:0]       face;
	logic [AO_W-1:0]         ao_packed;
	logic [KIND_W-1:0]       out_block_kind;
	logic [LEVEL_W-1:0]      face_light_level;
	logic                    last_face;

	voxel_item_t             pending_voxels [$];
	face_result_t            visible_faces_due [$];
	voxel_item_t             voxel_on_port;
	logic [KIND_W-1:0]       air_code_copy = '0;
	int                      voxels_queued = 0;
	int                      voxels_taken  = 0;
	int                      errors        = 0;
	int                      send_gap      = 0;
	int                      pop_gap       = 0;
	int                      idle_cycles   = 0;
	bit                      calm_send     = 1'b1;
	bit                      calm_recv     = 1'b1;

	voxel_face_cull_ambient_occlusion_core i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.push               (push),
		.full               (full),
		.x_pos              (x_pos),
		.y_pos              (y_pos),
		.z_pos              (z_pos),
		.block_kind         (block_kind),
		.neighborhood_solid (neighborhood_solid),
		.face_light         (face_light),
		.empty              (empty),
		.pop                (pop),
		.out_x              (out_x),
		.out_y              (out_y),
		.out_z              (out_z),
		.face               (face),
		.ao_packed          (ao_packed),
		.out_block_kind     (out_block_kind),
		.face_light_level   (face_light_level),
		.last_face          (last_face)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Grid position g runs over the 3x3 plane beside face f; position 4 lies across the face.
	function automatic int neighbor_bit(input int f, input int g);
		int u;
		int w;
		int n;
		int dx;
		int dy;
		int dz;
		u = g % 3 - 1;
		w = g / 3 - 1;
		n = (f % 2 == 1) ? 1 : -1;
		case (f / 2)
			0: begin
				dx = n; dy = w; dz = u;
			end
			1: begin
				dx = u; dy = n; dz = w;
			end
			default: begin
				dx = u; dy = w; dz = n;
			end
		endcase
		return (dx + 1) * 9 + (dy + 1) * 3 + (dz + 1);
	endfunction

	function automatic logic [AO_W-1:0] occlusion_of(input logic [HOOD_W-1:0] hood,
		input int f);
		logic [AO_W-1:0] ao_bits;
		int              solid [3];
		int              r;
		int              v;
		ao_bits = '0;
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 3; j++) begin
				r = VERTEX_REFS[f][3*k+j];
				solid[j] = hood[neighbor_bit(f, (r < 4) ? r : r + 1)];
			end
			if (solid[0] != 0 && solid[1] != 0) begin
				v = 0;
			end else begin
				v = 3 - (solid[0] + solid[1] + solid[2]);
			end
			ao_bits[2*k +: 2] = 2'(v);
		end
		return ao_bits;
	endfunction

	function automatic void emit_visible_faces(input voxel_item_t v);
		face_result_t r;
		int           n_faces;
		n_faces = 0;
		if (v.kind == air_code_copy) begin
			return;
		end
		for (int f = 0; f < NUM_FACES; f++) begin
			if (!v.hood[neighbor_bit(f, ACROSS_FACE)]) begin
				r.x     = v.x;
				r.y     = v.y;
				r.z     = v.z;
				r.dir   = face_dir_t'(f);
				r.ao    = occlusion_of(v.hood, f);
				r.kind  = v.kind;
				r.level = v.light[8*f +: 8];
				r.last  = 1'b0;
				visible_faces_due.insert(visible_faces_due.size(), r);
				n_faces++;
			end
		end
		if (n_faces > 0) begin
			visible_faces_due[visible_faces_due.size()-1].last = 1'b1;
		end
	endfunction

	function automatic int draw_wait(input bit calm);
		if (calm || $urandom_range(0, 1) == 0) begin
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void queue_voxel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z, input logic [KIND_W-1:0] kind,
		input logic [HOOD_W-1:0] hood, input logic [LIGHT_W-1:0] light);
		voxel_item_t v;
		v.x     = x;
		v.y     = y;
		v.z     = z;
		v.kind  = kind;
		v.hood  = hood;
		v.light = light;
		pending_voxels.insert(pending_voxels.size(), v);
		voxels_queued++;
	endfunction

	function automatic void queue_random_voxel();
		logic [HOOD_W-1:0]  a;
		logic [HOOD_W-1:0]  b;
		logic [HOOD_W-1:0]  hood;
		logic [KIND_W-1:0]  kind;
		logic [LIGHT_W-1:0] light;
		a = HOOD_W'($urandom);
		b = HOOD_W'($urandom);
		case ($urandom_range(0, 3))
			0: hood = a;
			1: hood = a | b;
			2: hood = a & b;
			default: hood = a | b | HOOD_W'($urandom);
		endcase
		kind  = ($urandom_range(0, 5) == 0) ? air_code_copy : KIND_W'($urandom);
		light = {16'($urandom), 32'($urandom)};
		if ($urandom_range(0, 3) == 0) begin
			for (int f = 0; f < NUM_FACES; f++) begin
				if ($urandom_range(0, 1) == 1) begin
					light[8*f +: 8] = MISSING_LIGHT;
				end
			end
		end
		queue_voxel(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), kind, hood, light);
	endfunction

	function automatic void compare_field(input string name, input logic [LIGHT_W-1:0] want,
		input logic [LIGHT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_air_code();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= AIR_CODE_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== APB_DATA_W'(air_code_copy)) begin
			$display("%0t: air code readback mismatch, expected %0h, actual %0h", $time,
				APB_DATA_W'(air_code_copy), prdata);
			errors++;
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_air_code(input logic [KIND_W-1:0] code);
		apb_write(AIR_CODE_ADDR, {24'($urandom), code});
		air_code_copy = code;
		check_air_code();
	endtask

	// Air and enclosed voxels leave no trace at the output, so a short settle follows the drain.
	task automatic wait_until_drained();
		while (voxels_taken != voxels_queued || visible_faces_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				emit_visible_faces(voxel_on_port);
				voxels_taken++;
			end
			if (!push || !full) begin
				if (send_gap != 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (pending_voxels.size() != 0) begin
					voxel_on_port      = pending_voxels.pop_front();
					x_pos              <= voxel_on_port.x;
					y_pos              <= voxel_on_port.y;
					z_pos              <= voxel_on_port.z;
					block_kind         <= voxel_on_port.kind;
					neighborhood_solid <= voxel_on_port.hood;
					face_light         <= voxel_on_port.light;
					push               <= 1'b1;
					send_gap           = draw_wait(calm_send);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : face_monitor
		face_result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (visible_faces_due.size() == 0) begin
					$display("%0t: face item with none expected, actual x=%0h y=%0h z=%0h face=%0h",
						$time, out_x, out_y, out_z, face);
					errors++;
				end else begin
					want = visible_faces_due.pop_front();
					compare_field("out_x", want.x, out_x);
					compare_field("out_y", want.y, out_y);
					compare_field("out_z", want.z, out_z);
					compare_field("face", want.dir, face);
					compare_field("ao_packed", want.ao, ao_packed);
					compare_field("out_block_kind", want.kind, out_block_kind);
					compare_field("face_light_level", want.level, face_light_level);
					compare_field("last_face", want.last, last_face);
				end
				pop_gap = draw_wait(calm_recv);
			end
			if (pop_gap != 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		logic [KIND_W-1:0] phase_air [4];
		phase_air[0] = KIND_W'($urandom);
		phase_air[1] = 8'h00;
		phase_air[2] = 8'hFF;
		phase_air[3] = KIND_W'($urandom);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		check_air_code();

		calm_send = 1'b0;
		calm_recv = 1'b0;
		queue_voxel(4'd0, 4'd0, 4'd0, 8'd0, '0, '1);
		queue_voxel(4'd15, 4'd15, 4'd15, 8'd1, '1, '1);
		queue_voxel(4'd0, 4'd0, 4'd0, 8'd1, '0, '0);
		queue_voxel(4'd15, 4'd15, 4'd15, 8'hFF, HOOD_W'(1) << 13, '1);
		for (int f = 0; f < NUM_FACES; f++) begin
			queue_voxel(COORD_W'(f), COORD_W'(15 - f), COORD_W'(2 * f), 8'h80 | KIND_W'(f),
				~(HOOD_W'(1) << neighbor_bit(f, ACROSS_FACE)), {6{MISSING_LIGHT}});
		end
		queue_voxel(4'h5, 4'hA, 4'h3, 8'h5A, 27'h5555555, 48'hA5A5_5A5A_0F0F);
		queue_voxel(4'hA, 4'h5, 4'hC, 8'hA5, 27'h2AAAAAA, {16'($urandom), 32'($urandom)});
		wait_until_drained();

		set_air_code(8'hFF);
		queue_voxel(4'd7, 4'd8, 4'd9, 8'hFF, '0, '1);
		queue_voxel(4'd9, 4'd8, 4'd7, 8'h00, '0, 48'h0102_0304_0506);
		queue_voxel(4'd3, 4'd12, 4'd6, 8'h7F, 27'h00001FF, {16'($urandom), 32'($urandom)});
		queue_voxel(4'd12, 4'd3, 4'd9, 8'hFE, 27'h7FC0000, {16'($urandom), 32'($urandom)});
		wait_until_drained();

		for (int p = 0; p < 4; p++) begin
			calm_send = (p == 0 || p == 3);
			calm_recv = (p == 0 || p == 2);
			set_air_code(phase_air[p]);
			if (p == 2) begin
				apb_write(SPARE_ADDR, $urandom);
				check_air_code();
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2) begin
					wait_until_drained();
				end
				queue_random_voxel();
			end
			wait_until_drained();
		end

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/vfcao_pkg.sv
rtl/vfcao_front.sv
rtl/vfcao_queue.sv
rtl/vfcao_back.sv
rtl/voxel_face_cull_ambient_occlusion_core.sv
sim/tb_voxel_face_cull_ambient_occlusion_core.sv
